// ===== hw/rtl/sliding_window_min_max_defines.svh =====
// Assertion macros shared by the sliding window min/max block
`ifndef SLIDING_WINDOW_MIN_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_DEFINES_SVH

// Implication checked in the same cycle
`define SWMM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swmm check failed");

// Implication checked in the following cycle
`define SWMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swmm check failed");

`endif

// ===== hw/rtl/swmm_pkg.sv =====
package swmm_pkg;

    // Configuration register widths
    localparam int WIN_BITS  = 7;
    localparam int CFG_BITS  = 7;
    localparam int IDX_BITS  = 1;

    // Configuration register indexes
    typedef enum logic [IDX_BITS-1:0] {
        CFG_WINDOW_SIZE  = 1'b0,
        CFG_EXTREME_MODE = 1'b1
    } cfg_index_t;

    // Output selection codes
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    // Per-beat control broadcast to every cell
    typedef struct packed {
        logic step;       // a sample beat is accepted this cycle
        logic clear;      // row start: cell contents count as empty
        logic retire;     // front entry leaves the window
        logic full_push;  // every entry kept: drop front, push at back
        logic mode;       // MODE_MAX or MODE_MIN
    } ctrl_t;

endpackage

// ===== hw/rtl/swmm_cell.sv =====
module swmm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int POS_BITS    = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swmm_pkg::ctrl_t        ctrl,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [POS_BITS-1:0]    cur_pos,
    // neighbor toward the back, seen when the front retires
    input  logic                   nxt_valid,
    input  logic [SAMPLE_BITS-1:0] nxt_value,
    input  logic [POS_BITS-1:0]    nxt_pos,
    // entry shifted in when the deque is full
    input  logic                   fill_valid,
    input  logic [SAMPLE_BITS-1:0] fill_value,
    input  logic [POS_BITS-1:0]    fill_pos,
    // keep chain
    input  logic                   keep_up,
    input  logic                   keep_prev,
    output logic                   keep,
    // stored entry
    output logic                   valid,
    output logic [SAMPLE_BITS-1:0] value,
    output logic [POS_BITS-1:0]    pos,
    output logic [SAMPLE_BITS-1:0] value_next
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_nx;
    logic [POS_BITS-1:0]    pos_reg;
    logic [POS_BITS-1:0]    pos_next;

    logic                   view_valid;
    logic [SAMPLE_BITS-1:0] view_value;
    logic [POS_BITS-1:0]    view_pos;
    logic                   pop;

    // Entry after the front retire shift; row start empties everything
    always_comb
    begin
        if (ctrl.retire)
        begin
            view_valid = nxt_valid & ~ctrl.clear;
            view_value = nxt_value;
            view_pos   = nxt_pos;
        end
        else
        begin
            view_valid = valid_reg & ~ctrl.clear;
            view_value = value_reg;
            view_pos   = pos_reg;
        end
    end

    // Dominated or equal entries leave from the back
    assign pop  = (ctrl.mode == swmm_pkg::MODE_MIN) ? (sample <= view_value)
                                                    : (sample >= view_value);
    assign keep = view_valid & (~pop | keep_up);

    // Next contents: shift on full push, keep, take the new sample, or empty
    always_comb
    begin
        valid_next = 1'b0;
        value_nx   = view_value;
        pos_next   = view_pos;
        if (ctrl.full_push)
        begin
            valid_next = fill_valid;
            value_nx   = fill_value;
            pos_next   = fill_pos;
        end
        else if (keep)
        begin
            valid_next = 1'b1;
        end
        else if (keep_prev)
        begin
            valid_next = 1'b1;
            value_nx   = sample;
            pos_next   = cur_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            value_reg <= value_nx;
            pos_reg   <= pos_next;
        end
    end

    assign valid      = valid_reg;
    assign value      = value_reg;
    assign pos        = pos_reg;
    assign value_next = value_nx;

endmodule

// ===== hw/rtl/sliding_window_min_max.sv =====
// Sliding window maximum or minimum over a sample stream. Takes one sample
// beat per clock and, once the row holds window_size samples, returns the
// max (extreme_mode 0) or min (extreme_mode 1) of the latest window_size
// samples in the cycle after the sample beat. Candidates live in a row of
// WINDOW_MAX cells with the front of the deque in cell 0; every cell compares
// the new sample in parallel and a keep chain running through all cells,
// which sets the clock period, decides which candidates survive. Input stalls
// only while a result sits in the output register and the sink stalls.
// row_start empties the window before its sample is taken in; window_size
// zero acts as 1 and sizes above WINDOW_MAX act as WINDOW_MAX. No clearing
// pass after reset.
`include "sliding_window_min_max_defines.svh"

module sliding_window_min_max #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int ROW_MAX     = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [swmm_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [swmm_pkg::CFG_BITS-1:0]     cfg_data,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic                              row_start,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [SAMPLE_BITS-1:0]            window_extreme
);

    localparam int POS_BITS = (ROW_MAX > 2) ? $clog2(ROW_MAX) : 1;
    localparam int CMP_BITS = POS_BITS + swmm_pkg::WIN_BITS + 1;
    localparam int WIN_CAP  = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
    localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(ROW_MAX - 1);

    // Configuration registers
    logic [swmm_pkg::WIN_BITS-1:0] window_size_reg;
    logic                          extreme_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= swmm_pkg::WIN_BITS'(1);
            extreme_mode_reg <= swmm_pkg::MODE_MAX;
        end
        else if (cfg_we)
        begin
            unique case (swmm_pkg::cfg_index_t'(cfg_index))
                swmm_pkg::CFG_WINDOW_SIZE:  window_size_reg  <= cfg_data;
                swmm_pkg::CFG_EXTREME_MODE: extreme_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective window length
    logic [swmm_pkg::WIN_BITS-1:0] win_k;

    always_comb
    begin
        if (window_size_reg == '0)
            win_k = swmm_pkg::WIN_BITS'(1);
        else if (window_size_reg > swmm_pkg::WIN_BITS'(WIN_CAP))
            win_k = swmm_pkg::WIN_BITS'(WIN_CAP);
        else
            win_k = window_size_reg;
    end

    // Handshake
    logic out_valid_reg;
    logic out_valid_next;
    logic [SAMPLE_BITS-1:0] out_value_reg;
    logic in_accept;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // Row position
    logic [POS_BITS-1:0] row_pos_reg;
    logic [POS_BITS-1:0] row_pos_next;
    logic [POS_BITS-1:0] cur_pos;

    assign cur_pos = row_start ? '0 : row_pos_reg;

    always_comb
    begin
        row_pos_next = row_pos_reg;
        if (in_accept)
            row_pos_next = (cur_pos < POS_LAST) ? cur_pos + POS_BITS'(1) : cur_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_pos_reg <= '0;
        else
            row_pos_reg <= row_pos_next;
    end

    // Cell chain wiring
    logic [WINDOW_MAX-1:0]  cell_valid;
    logic [WINDOW_MAX-1:0]  cell_keep;
    logic [SAMPLE_BITS-1:0] cell_value   [WINDOW_MAX];
    logic [POS_BITS-1:0]    cell_pos     [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_vnext   [WINDOW_MAX];
    swmm_pkg::ctrl_t        ctrl;
    logic                   retire;
    logic                   emit;

    // Front leaves the window once its position plus the window reaches now
    assign retire = cell_valid[0] & ~row_start &
                    ((CMP_BITS'(cell_pos[0]) + CMP_BITS'(win_k)) <= CMP_BITS'(cur_pos));

    assign ctrl.step      = in_accept;
    assign ctrl.clear     = row_start;
    assign ctrl.retire    = retire;
    assign ctrl.full_push = cell_keep[WINDOW_MAX-1];
    assign ctrl.mode      = extreme_mode_reg;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            logic                   nxt_valid;
            logic [SAMPLE_BITS-1:0] nxt_value;
            logic [POS_BITS-1:0]    nxt_pos;
            logic                   fill_valid;
            logic [SAMPLE_BITS-1:0] fill_value;
            logic [POS_BITS-1:0]    fill_pos;
            logic                   keep_up;
            logic                   keep_prev;

            if (gi == WINDOW_MAX - 1)
            begin : g_last
                assign nxt_valid  = 1'b0;
                assign nxt_value  = sample;
                assign nxt_pos    = cur_pos;
                assign fill_valid = 1'b1;
                assign fill_value = sample;
                assign fill_pos   = cur_pos;
                assign keep_up    = 1'b0;
            end
            else
            begin : g_mid
                assign nxt_valid  = cell_valid[gi+1];
                assign nxt_value  = cell_value[gi+1];
                assign nxt_pos    = cell_pos[gi+1];
                assign fill_valid = cell_valid[gi+1];
                assign fill_value = cell_value[gi+1];
                assign fill_pos   = cell_pos[gi+1];
                assign keep_up    = cell_keep[gi+1];
            end

            if (gi == 0)
            begin : g_first
                assign keep_prev = 1'b1;
            end
            else
            begin : g_rest
                assign keep_prev = cell_keep[gi-1];
            end

            swmm_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .POS_BITS    (POS_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sample     (sample),
                .cur_pos    (cur_pos),
                .nxt_valid  (nxt_valid),
                .nxt_value  (nxt_value),
                .nxt_pos    (nxt_pos),
                .fill_valid (fill_valid),
                .fill_value (fill_value),
                .fill_pos   (fill_pos),
                .keep_up    (keep_up),
                .keep_prev  (keep_prev),
                .keep       (cell_keep[gi]),
                .valid      (cell_valid[gi]),
                .value      (cell_value[gi]),
                .pos        (cell_pos[gi]),
                .value_next (cell_vnext[gi])
            );
        end
    endgenerate

    // Result once the row holds a full window
    assign emit = in_accept &
                  ((CMP_BITS'(cur_pos) + CMP_BITS'(1)) >= CMP_BITS'(win_k));

    assign out_valid_next = emit | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_value_reg <= cell_vnext[0];
    end

    assign out_valid      = out_valid_reg;
    assign window_extreme = out_value_reg;

    // Checks
    `SWMM_ASSERT_SAME(a_valid_prefix, 1'b1,
        ((cell_valid & (cell_valid + WINDOW_MAX'(1))) == '0))
    `SWMM_ASSERT_NEXT(a_row_start_single, in_accept && row_start,
        (cell_valid == WINDOW_MAX'(1)))
    `SWMM_ASSERT_SAME(a_pos_saturates, 1'b1, (row_pos_reg <= POS_LAST))

endmodule
